>>> src/sip_pkg.sv
package sip_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int EPS_BITS   = 40;

  // Differences need one more bit than a coordinate, products twice that,
  // and the sum of two products one more.
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int DET_BITS  = PROD_BITS + 1;
  localparam int CMP_BITS  = (DET_BITS > EPS_BITS) ? DET_BITS : EPS_BITS;
  localparam int KMUL_BITS = FRAC_BITS + 2 + DIFF_BITS;

  localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

  localparam logic [1:0] ST_CROSS    = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p_x;
    logic signed [COORD_BITS-1:0] p_y;
    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
  } in_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [FRAC_BITS:0]           k_frac;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } out_t;

endpackage

>>> src/segment_intersection_point.sv
// Segment crossing point, fully pipelined: one word is accepted every cycle
// while in_stall is low, and its result passes through twenty-three register
// stages (five for differences, products, determinant sums, sign normalization
// and classification, sixteen restoring divider stages that produce one bit of
// k each, then the k times PQ product and the final add). in_stall rises only
// when every stage holds a word and the output is stalled. det_epsilon is
// written through cfg_we / cfg_wdata and resets to 1.
module segment_intersection_point (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sip_pkg::in_t           in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sip_pkg::out_t          out_word,
  input  logic                   cfg_we,
  input  logic [sip_pkg::EPS_BITS-1:0] cfg_wdata
);

  localparam int C  = sip_pkg::COORD_BITS;
  localparam int F  = sip_pkg::FRAC_BITS;
  localparam int D  = sip_pkg::DIFF_BITS;
  localparam int P  = sip_pkg::PROD_BITS;
  localparam int W  = sip_pkg::DET_BITS;
  localparam int KM = sip_pkg::KMUL_BITS;
  localparam int NS = F + 7;
  localparam int S_CLASS = 4;
  localparam int S_KMUL  = F + 5;

  typedef struct packed {
    logic [W-2:0]          rem;
    logic [W-2:0]          det;
    logic [F-1:0]          k;
    logic [1:0]            status;
    logic                  eq;
    logic signed [C-1:0]   px;
    logic signed [C-1:0]   py;
    logic signed [D-1:0]   pqx;
    logic signed [D-1:0]   pqy;
  } div_t;

  logic [sip_pkg::EPS_BITS-1:0] eps_r;
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // stage 0: differences
  logic signed [C-1:0] s0_px_r, s0_py_r;
  logic signed [D-1:0] s0_pqx_r, s0_pqy_r, s0_abx_r, s0_aby_r, s0_pax_r, s0_pay_r;
  // stage 1: products
  logic signed [C-1:0] s1_px_r, s1_py_r;
  logic signed [D-1:0] s1_pqx_r, s1_pqy_r;
  logic signed [P-1:0] s1_m0_r, s1_m1_r, s1_m2_r, s1_m3_r, s1_m4_r, s1_m5_r;
  // stage 2: determinant and numerators
  logic signed [C-1:0] s2_px_r, s2_py_r;
  logic signed [D-1:0] s2_pqx_r, s2_pqy_r;
  logic signed [W-1:0] s2_det_r, s2_kn_r, s2_ln_r;
  // stage 3: determinant made non-negative
  logic signed [C-1:0] s3_px_r, s3_py_r;
  logic signed [D-1:0] s3_pqx_r, s3_pqy_r;
  logic [W-2:0]        s3_det_r;
  logic signed [W-1:0] s3_kn_r, s3_ln_r;
  logic signed [W-1:0] s3_det_nxt, s3_kn_nxt, s3_ln_nxt;
  // stage 4 and divider stages
  div_t dv_r   [0:F];
  div_t dv_nxt [0:F];
  logic         par;
  logic         outside;
  // k times PQ
  logic [1:0]           km_status_r;
  logic [F:0]           km_k_r;
  logic [F:0]           km_k_nxt;
  logic signed [C-1:0]  km_px_r, km_py_r;
  logic signed [KM-1:0] km_x_r, km_y_r;
  // output
  sip_pkg::out_t        out_r;
  sip_pkg::out_t        out_nxt;
  logic signed [KM-1:0] cx_full, cy_full;

  // A stage may load when it is empty or when the one after it moves on.
  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NS-1];
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= sip_pkg::EPS_RESET;
      v_r   <= '0;
    end else begin
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_px_r  <= in_word.p_x;
      s0_py_r  <= in_word.p_y;
      s0_pqx_r <= D'(in_word.q_x) - D'(in_word.p_x);
      s0_pqy_r <= D'(in_word.q_y) - D'(in_word.p_y);
      s0_abx_r <= D'(in_word.b_x) - D'(in_word.a_x);
      s0_aby_r <= D'(in_word.b_y) - D'(in_word.a_y);
      s0_pax_r <= D'(in_word.a_x) - D'(in_word.p_x);
      s0_pay_r <= D'(in_word.a_y) - D'(in_word.p_y);
    end
    if (en[1]) begin
      s1_px_r  <= s0_px_r;
      s1_py_r  <= s0_py_r;
      s1_pqx_r <= s0_pqx_r;
      s1_pqy_r <= s0_pqy_r;
      s1_m0_r  <= s0_pqx_r * s0_aby_r;
      s1_m1_r  <= s0_abx_r * s0_pqy_r;
      s1_m2_r  <= s0_pax_r * s0_aby_r;
      s1_m3_r  <= s0_abx_r * s0_pay_r;
      s1_m4_r  <= s0_pax_r * s0_pqy_r;
      s1_m5_r  <= s0_pqx_r * s0_pay_r;
    end
    if (en[2]) begin
      s2_px_r  <= s1_px_r;
      s2_py_r  <= s1_py_r;
      s2_pqx_r <= s1_pqx_r;
      s2_pqy_r <= s1_pqy_r;
      s2_det_r <= W'(s1_m0_r) - W'(s1_m1_r);
      s2_kn_r  <= W'(s1_m2_r) - W'(s1_m3_r);
      s2_ln_r  <= W'(s1_m4_r) - W'(s1_m5_r);
    end
    if (en[3]) begin
      s3_px_r  <= s2_px_r;
      s3_py_r  <= s2_py_r;
      s3_pqx_r <= s2_pqx_r;
      s3_pqy_r <= s2_pqy_r;
      s3_det_r <= s3_det_nxt[W-2:0];
      s3_kn_r  <= s3_kn_nxt;
      s3_ln_r  <= s3_ln_nxt;
    end
  end

  always_comb begin
    if (s2_det_r < 0) begin
      s3_det_nxt = -s2_det_r;
      s3_kn_nxt  = -s2_kn_r;
      s3_ln_nxt  = -s2_ln_r;
    end else begin
      s3_det_nxt = s2_det_r;
      s3_kn_nxt  = s2_kn_r;
      s3_ln_nxt  = s2_ln_r;
    end
  end

  // Classification: both parameters in [0,1] means 0 <= num <= det.
  always_comb begin
    par = (s3_det_r == '0) ||
          (sip_pkg::CMP_BITS'(s3_det_r) < sip_pkg::CMP_BITS'(eps_r));
    outside = (s3_kn_r < 0) || (s3_kn_r > $signed({1'b0, s3_det_r})) ||
              (s3_ln_r < 0) || (s3_ln_r > $signed({1'b0, s3_det_r}));
    dv_nxt[0].rem = s3_kn_r[W-2:0];
    dv_nxt[0].det = s3_det_r;
    dv_nxt[0].k   = '0;
    dv_nxt[0].eq  = (s3_kn_r == $signed({1'b0, s3_det_r}));
    dv_nxt[0].px  = s3_px_r;
    dv_nxt[0].py  = s3_py_r;
    dv_nxt[0].pqx = s3_pqx_r;
    dv_nxt[0].pqy = s3_pqy_r;
    if (par) begin
      dv_nxt[0].status = sip_pkg::ST_PARALLEL;
    end else if (outside) begin
      dv_nxt[0].status = sip_pkg::ST_OUTSIDE;
    end else begin
      dv_nxt[0].status = sip_pkg::ST_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_CLASS]) begin
      dv_r[0] <= dv_nxt[0];
    end
  end

  // Restoring divider, one quotient bit per stage; for a crossing word rem stays
  // no larger than det, so the subtraction fits in the remainder width.
  for (genvar j = 0; j < F; j++) begin : g_div
    logic [W-1:0] rem2;
    logic         ge;
    always_comb begin
      rem2 = {dv_r[j].rem, 1'b0};
      ge   = (rem2 >= {1'b0, dv_r[j].det});
      dv_nxt[j+1]     = dv_r[j];
      dv_nxt[j+1].k   = {dv_r[j].k[F-2:0], ge};
      dv_nxt[j+1].rem = ge ? (rem2[W-2:0] - dv_r[j].det) : rem2[W-2:0];
    end
    always_ff @(posedge clk) begin
      if (en[S_CLASS+1+j]) begin
        dv_r[j+1] <= dv_nxt[j+1];
      end
    end
  end

  // Parameter exactly one gives k = 1.0 and the point Q.
  assign km_k_nxt = dv_r[F].eq ? (F+1)'(1) << F : {1'b0, dv_r[F].k};

  always_ff @(posedge clk) begin
    if (en[S_KMUL]) begin
      km_status_r <= dv_r[F].status;
      km_k_r      <= km_k_nxt;
      km_px_r     <= dv_r[F].px;
      km_py_r     <= dv_r[F].py;
      km_x_r      <= $signed({1'b0, km_k_nxt}) * dv_r[F].pqx;
      km_y_r      <= $signed({1'b0, km_k_nxt}) * dv_r[F].pqy;
    end
  end

  always_comb begin
    cx_full = KM'(km_px_r) + (km_x_r >>> F);
    cy_full = KM'(km_py_r) + (km_y_r >>> F);
    out_nxt.status = km_status_r;
    if (km_status_r == sip_pkg::ST_CROSS) begin
      out_nxt.k_frac  = km_k_r;
      out_nxt.cross_x = cx_full[C-1:0];
      out_nxt.cross_y = cy_full[C-1:0];
    end else begin
      out_nxt.k_frac  = '0;
      out_nxt.cross_x = '0;
      out_nxt.cross_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_r <= out_nxt;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == sip_pkg::ST_CROSS ||
                   out_word.status == sip_pkg::ST_PARALLEL ||
                   out_word.status == sip_pkg::ST_OUTSIDE))
    else $error("undefined status code");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != sip_pkg::ST_CROSS) |->
      (out_word.k_frac == '0 && out_word.cross_x == '0 && out_word.cross_y == '0))
    else $error("nonzero fields on a word without a crossing");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.k_frac <= ((F+1)'(1) << F)))
    else $error("k_frac above one");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&v_r)))
    else $error("input stalled with room in the pipeline");

endmodule
